[sv/cpe_pkg.sv]
// Shared types, codes and constants for the control packet endpoint.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package cpe_pkg;

    localparam int PACKET_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] HDR_C        = 8'h43;
    localparam logic [7:0] HDR_P        = 8'h50;
    localparam logic [7:0] PROTO_VER    = 8'h02;
    localparam logic [7:0] TYPE_STATUS  = 8'h80;
    localparam logic [7:0] TYPE_INPUT   = 8'h81;
    localparam logic [7:0] STATUS_CAPS  = 8'h1F;
    localparam logic [7:0] STATUS_NCTRL = 8'h09;
    localparam logic [7:0] STATUS_NROT  = 8'h06;
    localparam logic [7:0] OP_LED_LO    = 8'h10;
    localparam logic [7:0] OP_LED_HI    = 8'h12;
    localparam logic [7:0] OP_ACTION    = 8'h20;
    localparam logic [7:0] OP_STATUS    = 8'h30;
    localparam logic [7:0] OP_RELEASE   = 8'h31;

    localparam logic [3:0] NUM_CONTROLS = 4'd9;

    localparam logic [1:0] ST_RELEASE = 2'd0;
    localparam logic [1:0] ST_PRESS   = 2'd1;
    localparam logic [1:0] ST_ROTATE  = 2'd2;

    typedef enum logic [1:0] {
        CMD_BUTTON  = 2'd0,
        CMD_ROTATE  = 2'd1,
        CMD_RX_BYTE = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        CFG_MAJOR = 2'd0,
        CFG_MINOR = 2'd1,
        CFG_PATCH = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_REPORT  = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        VD_BAD_LENGTH = 3'd0,
        VD_BAD_PACKET = 3'd1,
        VD_LED        = 3'd2,
        VD_ACTION     = 3'd3,
        VD_STATUS     = 3'd4,
        VD_RELEASE    = 3'd5,
        VD_UNKNOWN    = 3'd6
    } verdict_t;

    typedef enum logic [1:0] {
        JOB_INPUT          = 2'd0,
        JOB_VERDICT        = 2'd1,
        JOB_VERDICT_STATUS = 2'd2
    } job_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE    = 2'd0,
        BK_VERDICT = 2'd1,
        BK_REPORT  = 2'd2
    } back_state_t;

    typedef struct packed {
        logic [7:0] major;
        logic [7:0] minor;
        logic [7:0] patch;
    } version_t;

    typedef struct packed {
        job_kind_t   kind;
        verdict_t    verdict;
        logic [3:0]  visible;
        logic [1:0]  ev_state;
        logic [7:0]  seq;
        logic [15:0] mask;
    } job_t;

    function automatic logic [3:0] remap(input logic [3:0] idx);
        logic [3:0] r;
        case (idx)
            4'd0:    r = 4'd2;
            4'd1:    r = 4'd1;
            4'd2:    r = 4'd0;
            4'd3:    r = 4'd5;
            4'd4:    r = 4'd4;
            4'd5:    r = 4'd3;
            4'd6:    r = 4'd6;
            4'd7:    r = 4'd7;
            4'd8:    r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/cpe_front.sv]
// Front end: accepts items, keeps mask, sequence and receive state, queues jobs.
// Depends on cpe_pkg.
`default_nettype none

module cpe_front #(
    parameter int PACKET_BYTES = cpe_pkg::PACKET_BYTES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_command,
    input  wire logic [3:0]       s_control_index,
    input  wire logic             s_pressed,
    input  wire logic [7:0]       s_rx_byte,
    input  wire logic             s_rx_last,
    input  wire logic             q_full,
    output logic                  q_push,
    output cpe_pkg::job_t         q_job
);

    localparam int CNT_W = $clog2(PACKET_BYTES + 2);

    logic [7:0]       seq_reg, seq_next;
    logic [15:0]      mask_reg, mask_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [7:0]       rx_xor_reg, rx_xor_next;
    logic             rx_hdr_ok_reg, rx_hdr_ok_next;
    logic [7:0]       rx_opcode_reg, rx_opcode_next;

    logic             accept;
    logic [3:0]       visible;
    logic [15:0]      bit_sel;
    cpe_pkg::verdict_t vd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign visible = cpe_pkg::remap(s_control_index);
    assign bit_sel = 16'd1 << visible;

    always_comb begin
        seq_next       = seq_reg;
        mask_next      = mask_reg;
        rx_count_next  = rx_count_reg;
        rx_xor_next    = rx_xor_reg;
        rx_hdr_ok_next = rx_hdr_ok_reg;
        rx_opcode_next = rx_opcode_reg;
        vd             = cpe_pkg::VD_UNKNOWN;
        q_push         = 1'b0;
        q_job.kind     = cpe_pkg::JOB_INPUT;
        q_job.verdict  = cpe_pkg::VD_BAD_LENGTH;
        q_job.visible  = visible;
        q_job.ev_state = cpe_pkg::ST_ROTATE;
        q_job.seq      = seq_reg + 8'd1;
        q_job.mask     = mask_reg;
        if (accept) begin
            case (s_command)
                cpe_pkg::CMD_BUTTON, cpe_pkg::CMD_ROTATE: begin
                    if (s_control_index < cpe_pkg::NUM_CONTROLS) begin
                        if (s_command == cpe_pkg::CMD_BUTTON) begin
                            mask_next = s_pressed ? (mask_reg | bit_sel)
                                                  : (mask_reg & ~bit_sel);
                            q_job.ev_state = s_pressed ? cpe_pkg::ST_PRESS
                                                       : cpe_pkg::ST_RELEASE;
                        end
                        seq_next   = seq_reg + 8'd1;
                        q_job.mask = mask_next;
                        q_push     = 1'b1;
                    end
                end
                cpe_pkg::CMD_RX_BYTE: begin
                    if (rx_count_reg == CNT_W'(0) && s_rx_byte != cpe_pkg::HDR_C)
                        rx_hdr_ok_next = 1'b0;
                    if (rx_count_reg == CNT_W'(1) && s_rx_byte != cpe_pkg::HDR_P)
                        rx_hdr_ok_next = 1'b0;
                    if (rx_count_reg == CNT_W'(2) && s_rx_byte != 8'd1
                            && s_rx_byte != 8'd2)
                        rx_hdr_ok_next = 1'b0;
                    if (rx_count_reg == CNT_W'(3))
                        rx_opcode_next = s_rx_byte;
                    rx_xor_next = rx_xor_reg ^ s_rx_byte;
                    if (rx_count_reg < CNT_W'(PACKET_BYTES + 1))
                        rx_count_next = rx_count_reg + CNT_W'(1);
                    if (s_rx_last) begin
                        if (rx_count_next != CNT_W'(PACKET_BYTES))
                            vd = cpe_pkg::VD_BAD_LENGTH;
                        else if (!rx_hdr_ok_next || rx_xor_next != 8'd0)
                            vd = cpe_pkg::VD_BAD_PACKET;
                        else if (rx_opcode_next inside
                                 {[cpe_pkg::OP_LED_LO:cpe_pkg::OP_LED_HI]})
                            vd = cpe_pkg::VD_LED;
                        else if (rx_opcode_next == cpe_pkg::OP_ACTION)
                            vd = cpe_pkg::VD_ACTION;
                        else if (rx_opcode_next == cpe_pkg::OP_STATUS)
                            vd = cpe_pkg::VD_STATUS;
                        else if (rx_opcode_next == cpe_pkg::OP_RELEASE)
                            vd = cpe_pkg::VD_RELEASE;
                        else
                            vd = cpe_pkg::VD_UNKNOWN;
                        // drop the packet state, ready for the next one
                        rx_count_next  = '0;
                        rx_xor_next    = 8'd0;
                        rx_hdr_ok_next = 1'b1;
                        rx_opcode_next = 8'd0;
                        if (vd == cpe_pkg::VD_RELEASE)
                            mask_next = 16'd0;
                        q_job.kind = (vd == cpe_pkg::VD_STATUS || vd == cpe_pkg::VD_RELEASE)
                                     ? cpe_pkg::JOB_VERDICT_STATUS : cpe_pkg::JOB_VERDICT;
                        q_job.verdict = vd;
                        q_job.mask    = mask_next;
                        q_push        = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= 8'd0;
            mask_reg      <= 16'd0;
            rx_count_reg  <= '0;
            rx_xor_reg    <= 8'd0;
            rx_hdr_ok_reg <= 1'b1;
            rx_opcode_reg <= 8'd0;
        end else begin
            seq_reg       <= seq_next;
            mask_reg      <= mask_next;
            rx_count_reg  <= rx_count_next;
            rx_xor_reg    <= rx_xor_next;
            rx_hdr_ok_reg <= rx_hdr_ok_next;
            rx_opcode_reg <= rx_opcode_next;
        end
    end

endmodule

`default_nettype wire

[sv/cpe_queue.sv]
// Short job queue between front and back ends.
// Depends on cpe_pkg.
`default_nettype none

module cpe_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire cpe_pkg::job_t push_job,
    output logic               full,
    output logic               pop_valid,
    input  wire logic          pop,
    output cpe_pkg::job_t      pop_job
);

    localparam int DEPTH = cpe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpe_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/cpe_back.sv]
// Back end: jobs to verdict and report items, one per cycle unless stalled.
// Depends on cpe_pkg.
`default_nettype none

module cpe_back #(
    parameter int PACKET_BYTES = cpe_pkg::PACKET_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cpe_pkg::version_t version,
    input  wire logic              q_valid,
    input  wire cpe_pkg::job_t     q_job,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_kind,
    output logic [7:0]             m_tx_byte,
    output logic                   m_tx_last,
    output logic [2:0]             m_verdict
);

    localparam int POS_W = $clog2(PACKET_BYTES);

    cpe_pkg::back_state_t state_reg, state_next;
    cpe_pkg::job_t        job_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [7:0]           sum_reg;

    logic                 m_valid_reg;
    cpe_pkg::kind_t       m_kind_reg;
    logic [7:0]           m_tx_byte_reg;
    logic                 m_tx_last_reg;
    cpe_pkg::verdict_t    m_verdict_reg;

    logic                 step, done, pos_end, is_input;
    logic [7:0]           rep_byte, out_byte;
    cpe_pkg::kind_t       out_kind;
    cpe_pkg::verdict_t    out_verdict;

    assign step     = (state_reg != cpe_pkg::BK_IDLE) && (!m_valid_reg || m_ready);
    assign pos_end  = (pos_reg == POS_W'(PACKET_BYTES - 1));
    assign is_input = (job_reg.kind == cpe_pkg::JOB_INPUT);
    assign done     = step && ((state_reg == cpe_pkg::BK_VERDICT
                                && job_reg.kind != cpe_pkg::JOB_VERDICT_STATUS)
                               || (state_reg == cpe_pkg::BK_REPORT && pos_end));
    assign q_pop    = q_valid && (state_reg == cpe_pkg::BK_IDLE || done);

    // report byte at the current position, before the checksum
    always_comb begin
        case (pos_reg)
            POS_W'(0):  rep_byte = cpe_pkg::HDR_C;
            POS_W'(1):  rep_byte = cpe_pkg::HDR_P;
            POS_W'(2):  rep_byte = cpe_pkg::PROTO_VER;
            POS_W'(3):  rep_byte = is_input ? cpe_pkg::TYPE_INPUT : cpe_pkg::TYPE_STATUS;
            POS_W'(4):  rep_byte = is_input ? job_reg.seq : version.major;
            POS_W'(5):  rep_byte = is_input ? {4'd0, job_reg.visible} : version.minor;
            POS_W'(6):  rep_byte = is_input ? {6'd0, job_reg.ev_state} : version.patch;
            POS_W'(7):  rep_byte = is_input ? job_reg.mask[7:0] : cpe_pkg::STATUS_CAPS;
            POS_W'(8):  rep_byte = is_input ? job_reg.mask[15:8] : cpe_pkg::STATUS_NCTRL;
            POS_W'(9):  rep_byte = is_input ? 8'd0 : cpe_pkg::STATUS_NROT;
            POS_W'(10): rep_byte = is_input ? 8'd0 : job_reg.mask[7:0];
            POS_W'(11): rep_byte = is_input ? 8'd0 : job_reg.mask[15:8];
            default:    rep_byte = 8'd0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        if (q_pop)
            state_next = (q_job.kind == cpe_pkg::JOB_INPUT) ? cpe_pkg::BK_REPORT
                                                           : cpe_pkg::BK_VERDICT;
        else if (done)
            state_next = cpe_pkg::BK_IDLE;
        else if (step && state_reg == cpe_pkg::BK_VERDICT)
            state_next = cpe_pkg::BK_REPORT;
    end

    always_comb begin
        out_kind    = cpe_pkg::KIND_REPORT;
        out_byte    = 8'd0;
        out_verdict = cpe_pkg::VD_BAD_LENGTH;
        case (state_reg)
            cpe_pkg::BK_VERDICT: begin
                out_kind    = cpe_pkg::KIND_VERDICT;
                out_verdict = job_reg.verdict;
            end
            cpe_pkg::BK_REPORT: begin
                out_byte = pos_end ? sum_reg : rep_byte;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
            pos_reg <= '0;
            sum_reg <= 8'd0;
        end else if (step && state_reg == cpe_pkg::BK_REPORT) begin
            pos_reg <= pos_reg + POS_W'(1);
            sum_reg <= sum_reg ^ rep_byte;
        end
        if (step) begin
            m_kind_reg    <= out_kind;
            m_tx_byte_reg <= out_byte;
            m_tx_last_reg <= (state_reg == cpe_pkg::BK_REPORT) && pos_end;
            m_verdict_reg <= out_verdict;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cpe_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (step)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_tx_byte = m_tx_byte_reg;
    assign m_tx_last = m_tx_last_reg;
    assign m_verdict = m_verdict_reg;

endmodule

`default_nettype wire

[sv/control_packet_endpoint_core.sv]
// Control packet endpoint: top level with version registers, front, queue, back.
// The first result item passes the queue, the back-end job register and the output register.
// Throughput: one item accepted per cycle while the queue has room; results leave
// one per cycle from the back end while m_ready allows, so an event yields PACKET_BYTES
// report items, a status or release-all packet a verdict and as many. Depends on cpe_pkg.
// Reset (aresetn low, synchronous) clears sequence, mask, receive state and queue.
`default_nettype none

module control_packet_endpoint_core #(
    parameter int PACKET_BYTES = cpe_pkg::PACKET_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [3:0]  s_control_index,
    input  wire logic        s_pressed,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_rx_last,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [7:0]       m_tx_byte,
    output logic             m_tx_last,
    output logic [2:0]       m_verdict,
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    cpe_pkg::version_t version_reg;
    cpe_pkg::job_t     push_job, pop_job;
    logic              push, q_full, q_valid, q_pop;

    // Register writes are always accepted; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cpe_pkg::CFG_MAJOR: version_reg.major <= cfg_data;
                cpe_pkg::CFG_MINOR: version_reg.minor <= cfg_data;
                cpe_pkg::CFG_PATCH: version_reg.patch <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: classify each item, update mask and receive state, hand on a job.
    cpe_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_control_index (s_control_index),
        .s_pressed       (s_pressed),
        .s_rx_byte       (s_rx_byte),
        .s_rx_last       (s_rx_last),
        .q_full          (q_full),
        .q_push          (push),
        .q_job           (push_job)
    );

    // Queue: let the front keep taking items while a report is still going out.
    cpe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_job   (pop_job)
    );

    // Back end: serialise each job into verdict and report items through an output register.
    cpe_back #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .version   (version_reg),
        .q_valid   (q_valid),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_tx_byte (m_tx_byte),
        .m_tx_last (m_tx_last),
        .m_verdict (m_verdict)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for control_packet_endpoint_core: directed rows, then random traffic.
// Holds its own model of report, mask and receive state to work out every result item.
// Depends on cpe_pkg and the core RTL only.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpe_pkg::*;

    localparam int PKT_BYTES    = PACKET_BYTES_DEF;
    localparam int MAX_PKT      = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 60;

    // command code the block must ignore
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    // older protocol version, still accepted on receive
    localparam logic [7:0] PROTO_VER_OLD = 8'h01;
    // physical control -> visible control, four bits per entry, control 0 in the low nibble
    localparam logic [35:0] VISIBLE_MAP  =
        {4'd8, 4'd7, 4'd6, 4'd3, 4'd4, 4'd5, 4'd0, 4'd1, 4'd2};
    // report bytes carry a zero verdict field
    localparam verdict_t VD_NONE = VD_BAD_LENGTH;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tx_byte;
        logic       tx_last;
        verdict_t   verdict;
    } link_item_t;

    typedef enum logic [2:0] {
        ROW_BUTTON,
        ROW_ROTATE,
        ROW_NOISE,
        ROW_PACKET,
        ROW_WRAP
    } row_kind_t;

    typedef enum logic [2:0] {
        FL_NONE,
        FL_BAD_C,
        FL_BAD_P,
        FL_BAD_VER,
        FL_VER1,
        FL_BAD_SUM
    } flaw_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [3:0] idx;
        logic       pressed;
        logic [7:0] opcode;
        logic [7:0] len;
        flaw_t      flaw;
        logic       has_want;
        verdict_t   want;
    } row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_command;
    logic [3:0] s_control_index;
    logic       s_pressed;
    logic [7:0] s_rx_byte;
    logic       s_rx_last;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_kind;
    logic [7:0] m_tx_byte;
    logic       m_tx_last;
    logic [2:0] m_verdict;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // endpoint state as the bench sees it
    logic [7:0]  ver_major_q, ver_minor_q, ver_patch_q;
    logic [7:0]  seq_q;
    logic [15:0] mask_q;
    logic [5:0]  rx_count_q;
    logic [7:0]  rx_sum_q;
    logic        rx_hdr_ok_q;
    logic [7:0]  rx_op_q;
    logic [7:0]  report_body [0:PKT_BYTES-1];

    link_item_t owed_items [$];
    row_t       directed_rows [$];

    int       mismatches = 0;
    int       counted_items = 0;
    int       cycle_count = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;
    logic     verdict_seen = 1'b0;
    verdict_t last_verdict = VD_NONE;

    control_packet_endpoint_core #(
        .PACKET_BYTES (PKT_BYTES)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_control_index (s_control_index),
        .s_pressed       (s_pressed),
        .s_rx_byte       (s_rx_byte),
        .s_rx_last       (s_rx_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_tx_byte       (m_tx_byte),
        .m_tx_last       (m_tx_last),
        .m_verdict       (m_verdict),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 10 ns clock, first rising edge at 5 ns
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side back-pressure: redraw ready on every falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hard stop in case the block hangs or an expected item never shows up.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("control_packet_endpoint_core: mismatch");
            $finish;
        end
    end

    // Zero the report, then lay down the common header.
    task automatic start_body(input logic [7:0] ptype);
        int i;
        for (i = 0; i < PKT_BYTES; i++) report_body[i] = 8'h00;
        report_body[0] = HDR_C;
        report_body[1] = HDR_P;
        report_body[2] = PROTO_VER;
        report_body[3] = ptype;
    endtask

    // Close the report with its XOR byte and queue all of it, one item per byte.
    task automatic emit_report();
        logic [7:0] sum;
        link_item_t it;
        int i;
        sum = 8'h00;
        for (i = 0; i < PKT_BYTES - 1; i++) sum ^= report_body[i];
        report_body[PKT_BYTES-1] = sum;
        for (i = 0; i < PKT_BYTES; i++) begin
            it.kind    = KIND_REPORT;
            it.tx_byte = report_body[i];
            it.tx_last = (i == PKT_BYTES - 1);
            it.verdict = VD_NONE;
            owed_items.push_back(it);
        end
    endtask

    // Advance the endpoint state by one accepted item and queue what it owes.
    task automatic step_endpoint(input logic [1:0] cmd, input logic [3:0] idx,
                                 input logic pr, input logic [7:0] rxb, input logic last);
        logic [5:0] pos;
        logic [3:0] vis;
        verdict_t   vd;
        link_item_t vitem;
        if (cmd == CMD_RX_BYTE) begin
            pos = rx_count_q;
            if (pos == 6'd0 && rxb != HDR_C) rx_hdr_ok_q = 1'b0;
            if (pos == 6'd1 && rxb != HDR_P) rx_hdr_ok_q = 1'b0;
            if (pos == 6'd2 && rxb != PROTO_VER_OLD && rxb != PROTO_VER) rx_hdr_ok_q = 1'b0;
            if (pos == 6'd3) rx_op_q = rxb;
            rx_sum_q ^= rxb;
            // byte count sticks one past a full packet
            if (rx_count_q < PKT_BYTES + 1) rx_count_q = rx_count_q + 6'd1;
            if (last) begin
                if (rx_count_q != PKT_BYTES) vd = VD_BAD_LENGTH;
                else if (!rx_hdr_ok_q || rx_sum_q != 8'h00) vd = VD_BAD_PACKET;
                else if (rx_op_q >= OP_LED_LO && rx_op_q <= OP_LED_HI) vd = VD_LED;
                else if (rx_op_q == OP_ACTION) vd = VD_ACTION;
                else if (rx_op_q == OP_STATUS) vd = VD_STATUS;
                else if (rx_op_q == OP_RELEASE) vd = VD_RELEASE;
                else vd = VD_UNKNOWN;
                rx_count_q  = 6'd0;
                rx_sum_q    = 8'h00;
                rx_hdr_ok_q = 1'b1;
                rx_op_q     = 8'h00;
                vitem.kind    = KIND_VERDICT;
                vitem.tx_byte = 8'h00;
                vitem.tx_last = 1'b0;
                vitem.verdict = vd;
                owed_items.push_back(vitem);
                // release-all drops the mask before the status report reads it
                if (vd == VD_RELEASE) mask_q = 16'h0000;
                if (vd == VD_STATUS || vd == VD_RELEASE) begin
                    start_body(TYPE_STATUS);
                    report_body[4]  = ver_major_q;
                    report_body[5]  = ver_minor_q;
                    report_body[6]  = ver_patch_q;
                    report_body[7]  = STATUS_CAPS;
                    report_body[8]  = STATUS_NCTRL;
                    report_body[9]  = STATUS_NROT;
                    report_body[10] = mask_q[7:0];
                    report_body[11] = mask_q[15:8];
                    emit_report();
                end
            end
        end else if (cmd != CMD_UNUSED && idx < NUM_CONTROLS) begin
            vis = VISIBLE_MAP[idx*4 +: 4];
            if (cmd == CMD_BUTTON) begin
                if (pr) mask_q = mask_q | (16'd1 << vis);
                else mask_q = mask_q & ~(16'd1 << vis);
            end
            // sequence is bumped before it goes out, and wraps at 8 bits
            seq_q = seq_q + 8'd1;
            start_body(TYPE_INPUT);
            report_body[4] = seq_q;
            report_body[5] = {4'd0, vis};
            if (cmd == CMD_BUTTON) report_body[6] = {6'd0, pr ? ST_PRESS : ST_RELEASE};
            else report_body[6] = {6'd0, ST_ROTATE};
            report_body[7] = mask_q[7:0];
            report_body[8] = mask_q[15:8];
            emit_report();
        end
    endtask

    // Sample both channels and the register port on each rising edge:
    // check the result first, then take register writes, then step the model.
    always @(posedge aclk) begin : monitor_p
        link_item_t want_item;
        if (!aresetn) begin
            ver_major_q <= 8'h00;
            ver_minor_q <= 8'h00;
            ver_patch_q <= 8'h00;
            seq_q       <= 8'h00;
            mask_q      <= 16'h0000;
            rx_count_q  <= 6'd0;
            rx_sum_q    <= 8'h00;
            rx_hdr_ok_q <= 1'b1;
            rx_op_q     <= 8'h00;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_items.size() == 0) begin
                    $error("result item with none expected: kind %0d byte %0h verdict %0d",
                           m_kind, m_tx_byte, m_verdict);
                    mismatches++;
                end else begin
                    want_item = owed_items.pop_front();
                    if (m_kind !== want_item.kind) begin
                        $error("kind: expected %0d, got %0d", want_item.kind, m_kind);
                        mismatches++;
                    end
                    if (m_tx_byte !== want_item.tx_byte) begin
                        $error("tx_byte: expected %0h, got %0h", want_item.tx_byte, m_tx_byte);
                        mismatches++;
                    end
                    if (m_tx_last !== want_item.tx_last) begin
                        $error("tx_last: expected %0d, got %0d", want_item.tx_last, m_tx_last);
                        mismatches++;
                    end
                    if (m_verdict !== want_item.verdict) begin
                        $error("verdict: expected %0d, got %0d", want_item.verdict, m_verdict);
                        mismatches++;
                    end
                    if (m_kind === KIND_VERDICT) begin
                        last_verdict = verdict_t'(m_verdict);
                        verdict_seen = 1'b1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAJOR: ver_major_q = cfg_data;
                    CFG_MINOR: ver_minor_q = cfg_data;
                    CFG_PATCH: ver_patch_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                step_endpoint(s_command, s_control_index, s_pressed, s_rx_byte, s_rx_last);
        end
    end

    // Offer one item from a falling edge and hold it until the block takes it.
    task automatic send_item(input logic [1:0] cmd, input logic [3:0] idx, input logic pr,
                             input logic [7:0] rxb, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_command       = cmd;
        s_control_index = idx;
        s_pressed       = pr;
        s_rx_byte       = rxb;
        s_rx_last       = last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        // ignored items do not count toward the budget
        if (cmd == CMD_RX_BYTE || (cmd != CMD_UNUSED && idx < NUM_CONTROLS))
            counted_items++;
    endtask

    // Button or rotation event; mostly real controls, now and then an out-of-range one.
    task automatic send_event();
        logic [3:0] idx;
        if ($urandom_range(9) == 0) idx = 4'($urandom_range(15, 9));
        else idx = 4'($urandom_range(8));
        send_item($urandom_range(1) ? CMD_ROTATE : CMD_BUTTON, idx, 1'($urandom),
                  8'($urandom), 1'($urandom));
    endtask

    // Build a packet with the chosen flaw and send len bytes of it, the last one marked.
    // Events may be slipped between bytes to check they leave the receive state alone.
    task automatic send_packet(input logic [7:0] opcode, input int len, input flaw_t flaw,
                               input int mix_pct);
        logic [7:0] pkt [0:MAX_PKT-1];
        logic [7:0] sum;
        int i;
        for (i = 0; i < MAX_PKT; i++) pkt[i] = 8'($urandom);
        pkt[0] = HDR_C;
        pkt[1] = HDR_P;
        pkt[2] = PROTO_VER;
        pkt[3] = opcode;
        case (flaw)
            FL_BAD_C:   pkt[0] = HDR_C ^ 8'($urandom_range(255, 1));
            FL_BAD_P:   pkt[1] = HDR_P ^ 8'($urandom_range(255, 1));
            FL_BAD_VER: pkt[2] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 3));
            FL_VER1:    pkt[2] = PROTO_VER_OLD;
            default: ;
        endcase
        sum = 8'h00;
        for (i = 0; i < PKT_BYTES - 1; i++) sum ^= pkt[i];
        pkt[PKT_BYTES-1] = sum;
        if (flaw == FL_BAD_SUM) pkt[PKT_BYTES-1] ^= 8'(1 << $urandom_range(7));
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < mix_pct) send_event();
            send_item(CMD_RX_BYTE, 4'($urandom), 1'($urandom), pkt[i], i == len - 1);
        end
    endtask

    // Drop valid, wait for every owed item, then give trailing items time to clear.
    task automatic settle();
        s_valid = 1'b0;
        while (owed_items.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [3:0] idx, input logic pr,
                           input logic [7:0] opcode, input logic [7:0] len, input flaw_t flaw,
                           input logic has_want, input verdict_t want);
        row_t r;
        r.kind     = kind;
        r.idx      = idx;
        r.pressed  = pr;
        r.opcode   = opcode;
        r.len      = len;
        r.flaw     = flaw;
        r.has_want = has_want;
        r.want     = want;
        directed_rows.push_back(r);
    endtask

    // Mostly packets with random opcodes, some broken or of a wrong length; the rest events and noise.
    task automatic run_random(input int budget);
        int         stop_at;
        int         r;
        int         len;
        flaw_t      flaw;
        logic [7:0] op;
        stop_at = counted_items + budget;
        while (counted_items < stop_at) begin
            r = $urandom_range(99);
            if (r < 30) begin
                send_event();
            end else if (r < 35) begin
                send_item(CMD_UNUSED, 4'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                case ($urandom_range(7))
                    0:       op = OP_LED_LO;
                    1:       op = OP_LED_LO + 8'd1;
                    2:       op = OP_LED_HI;
                    3:       op = OP_ACTION;
                    4:       op = OP_STATUS;
                    5:       op = OP_RELEASE;
                    default: op = 8'($urandom);
                endcase
                r = $urandom_range(99);
                if (r < 70) flaw = FL_NONE;
                else if (r < 76) flaw = FL_BAD_C;
                else if (r < 82) flaw = FL_BAD_P;
                else if (r < 88) flaw = FL_BAD_VER;
                else if (r < 94) flaw = FL_VER1;
                else flaw = FL_BAD_SUM;
                len = ($urandom_range(99) < 85) ? PKT_BYTES : $urandom_range(40, 1);
                send_packet(op, len, flaw, 8);
            end
        end
    endtask

    initial begin : stimulus_p
        row_t r;
        int   phase;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_command       = CMD_BUTTON;
        s_control_index = 4'd0;
        s_pressed       = 1'b0;
        s_rx_byte       = 8'h00;
        s_rx_last       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_MAJOR;
        cfg_data        = 8'h00;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows run with registers still at their reset values.
        // Status request straight after reset: zero versions, zero mask.
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd32, FL_NONE, 1'b1, VD_STATUS);
        // presses at both ends of the control range, one rotation, one release
        add_row(ROW_BUTTON, 4'd0, 1'b1, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);
        add_row(ROW_BUTTON, 4'd8, 1'b1, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);
        add_row(ROW_BUTTON, 4'd3, 1'b1, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);
        add_row(ROW_ROTATE, 4'd4, 1'b0, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);
        add_row(ROW_BUTTON, 4'd0, 1'b0, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);
        // out-of-range controls and the spare command: nothing comes back
        add_row(ROW_BUTTON, 4'd9, 1'b1, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);
        add_row(ROW_ROTATE, 4'd15, 1'b0, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);
        add_row(ROW_NOISE, 4'd0, 1'b1, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);
        // LED, action and unknown opcodes, old protocol version on one of them
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_LED_LO, 8'd32, FL_NONE, 1'b1, VD_LED);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_LED_HI, 8'd32, FL_VER1, 1'b1, VD_LED);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_ACTION, 8'd32, FL_NONE, 1'b1, VD_ACTION);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_LED_HI + 8'd1, 8'd32, FL_NONE, 1'b1, VD_UNKNOWN);
        add_row(ROW_PACKET, 4'd0, 1'b0, 8'hFF, 8'd32, FL_NONE, 1'b1, VD_UNKNOWN);
        // header, version and checksum faults
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd32, FL_BAD_C, 1'b1, VD_BAD_PACKET);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd32, FL_BAD_P, 1'b1, VD_BAD_PACKET);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd32, FL_BAD_VER, 1'b1, VD_BAD_PACKET);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd32, FL_BAD_SUM, 1'b1, VD_BAD_PACKET);
        // short, one-byte, one-over and far-overlong packets; the long one saturates the count
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd31, FL_NONE, 1'b1, VD_BAD_LENGTH);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd1, FL_NONE, 1'b1, VD_BAD_LENGTH);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd33, FL_NONE, 1'b1, VD_BAD_LENGTH);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd70, FL_NONE, 1'b1, VD_BAD_LENGTH);
        // release-all with buttons held, then a status request on the cleared mask
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_RELEASE, 8'd32, FL_NONE, 1'b1, VD_RELEASE);
        add_row(ROW_PACKET, 4'd0, 1'b0, OP_STATUS, 8'd32, FL_NONE, 1'b0, VD_NONE);
        // run the report sequence all the way round
        add_row(ROW_WRAP, 4'd0, 1'b0, 8'h00, 8'd0, FL_NONE, 1'b0, VD_NONE);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            verdict_seen = 1'b0;
            case (r.kind)
                ROW_BUTTON: send_item(CMD_BUTTON, r.idx, r.pressed, 8'h00, 1'b0);
                ROW_ROTATE: send_item(CMD_ROTATE, r.idx, r.pressed, 8'hFF, 1'b1);
                ROW_NOISE:  send_item(CMD_UNUSED, r.idx, r.pressed, 8'hFF, 1'b1);
                ROW_PACKET: send_packet(r.opcode, r.len, r.flaw, 0);
                default:    repeat (256) send_item(CMD_ROTATE, 4'($urandom_range(8)),
                                                   1'b0, 8'h00, 1'b0);
            endcase
            // hold until the verdict is out, then compare it with the typed-in one
            if (r.has_want) begin
                settle();
                if (!verdict_seen || last_verdict != r.want) begin
                    $error("verdict: expected %0d, got %0d", r.want, last_verdict);
                    mismatches++;
                end
            end
        end

        // Random phases, each with fresh version registers and its own idling pattern.
        for (phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                    write_reg(CFG_MAJOR, 8'hFF);
                    write_reg(CFG_MINOR, 8'h00);
                    write_reg(CFG_PATCH, 8'hFF);
                end
                1: begin
                    src_idle_pct = 48; sink_stall_pct = 0;
                    write_reg(CFG_MAJOR, 8'h00);
                    write_reg(CFG_MINOR, 8'hFF);
                    write_reg(CFG_PATCH, 8'h00);
                end
                2: begin
                    src_idle_pct = 0;  sink_stall_pct = 48;
                    write_reg(CFG_MAJOR, 8'($urandom));
                    write_reg(CFG_MINOR, 8'($urandom));
                    write_reg(CFG_PATCH, 8'($urandom));
                end
                default: begin
                    src_idle_pct = 16; sink_stall_pct = 16;
                    write_reg(CFG_MAJOR, 8'hFF);
                    write_reg(CFG_MINOR, 8'hFF);
                    write_reg(CFG_PATCH, 8'hFF);
                end
            endcase
            run_random(PHASE_ITEMS);
        end

        settle();
        if (mismatches == 0)
            $display("control_packet_endpoint_core: match");
        else
            $display("control_packet_endpoint_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
